[src/pva_pkg.sv]
// shared types, constants and tuning tables of the polyphonic voice allocator
package pva_pkg;

  localparam int unsigned VoicesDef = 8;
  localparam int unsigned NumKeys   = 128;
  localparam int unsigned KeyW      = 7;
  localparam int unsigned VelW      = 7;
  localparam int unsigned TuneW     = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned PitchW    = 24;
  localparam int unsigned MaskW     = 8;
  localparam int unsigned VoiceOutW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOctave = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFifth  = 1'b1;

  localparam logic [TuneW-1:0] TuneReset = 7'd64;

  // tempered step sizes in 1/10 cent, before adding the register value
  localparam logic signed [14:0] OctaveBase = 15'sd11936;
  localparam logic signed [14:0] FifthBase  = 15'sd6936;
  // just octave in 1/200 cent
  localparam logic signed [21:0] JiOctave   = 22'sd240000;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_GLIDE   = 2'd2,
    ACT_RELEASE = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY,
    ST_GLIDE,
    ST_RR,
    ST_REL,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] note;
    logic [VelW-1:0] level;
  } voice_t;

  // just intonation above c in 1/200 cent
  function automatic logic [17:0] ji_cents(input logic [3:0] n);
    logic [17:0] r;
    case (n)
      4'd0:    r = 18'd0;
      4'd1:    r = 18'd20991;
      4'd2:    r = 18'd40782;
      4'd3:    r = 18'd59503;
      4'd4:    r = 18'd77263;
      4'd5:    r = 18'd94156;
      4'd6:    r = 18'd110264;
      4'd7:    r = 18'd140391;
      4'd8:    r = 18'd168106;
      4'd9:    r = 18'd181173;
      4'd10:   r = 18'd193765;
      4'd11:   r = 18'd217654;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

  // octave steps of a note from c
  function automatic logic signed [3:0] oct_step(input logic [3:0] n);
    logic signed [3:0] r;
    case (n)
      4'd0:    r = 4'sd0;
      4'd1:    r = -4'sd4;
      4'd2:    r = -4'sd1;
      4'd3:    r = 4'sd2;
      4'd4:    r = -4'sd2;
      4'd5:    r = 4'sd1;
      4'd6:    r = -4'sd3;
      4'd7:    r = 4'sd0;
      4'd8:    r = -4'sd4;
      4'd9:    r = -4'sd1;
      4'd10:   r = 4'sd2;
      4'd11:   r = -4'sd2;
      default: r = 4'sd0;
    endcase
    return r;
  endfunction

  // fifth steps of a note from c
  function automatic logic signed [4:0] fifth_step(input logic [3:0] n);
    logic signed [4:0] r;
    case (n)
      4'd0:    r = 5'sd0;
      4'd1:    r = 5'sd7;
      4'd2:    r = 5'sd2;
      4'd3:    r = -5'sd3;
      4'd4:    r = 5'sd4;
      4'd5:    r = -5'sd1;
      4'd6:    r = 5'sd6;
      4'd7:    r = 5'sd1;
      4'd8:    r = 5'sd8;
      4'd9:    r = 5'sd3;
      4'd10:   r = -5'sd2;
      4'd11:   r = 5'sd5;
      default: r = 5'sd0;
    endcase
    return r;
  endfunction

endpackage

[src/poly_voice_allocator.sv]
// polyphonic voice allocator: pressed-key map and voice table in block memories
// an ignored event skips the voice scan; a release scans the voice table once, a note on
//   scans for an adjacent voice and then round-robin for a free one (one voice read per cycle)
// throughput: one event at a time; the next event is taken while a result waits
// reset: a clearing pass over the 128 keys wipes the key map and voice table, input held off
module poly_voice_allocator #(
  parameter int unsigned VOICES = pva_pkg::VoicesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [pva_pkg::KeyW-1:0]      key_i,
  input  logic [pva_pkg::VelW-1:0]      velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    action_o,
  output logic [pva_pkg::VoiceOutW-1:0] voice_o,
  output logic [pva_pkg::MaskW-1:0]     release_mask_o,
  output logic signed [pva_pkg::PitchW-1:0] pitch_o,
  output logic [pva_pkg::VelW-1:0]      level_o,
  input  logic                          cfg_we_i,
  input  logic [pva_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pva_pkg::TuneW-1:0]     cfg_data_i
);
  import pva_pkg::*;

  localparam int unsigned VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CntW = VW + 1;

  // memories
  logic   pk_mem [NumKeys];
  voice_t vm_mem [VOICES];

  logic            pk_we;
  logic [KeyW-1:0] pk_waddr;
  logic            pk_wdata;
  logic            pk_rdata_q;

  logic          vm_we;
  logic [VW-1:0] vm_waddr;
  logic [VW-1:0] vm_raddr;
  voice_t        vm_wdata;
  voice_t        vm_rdata_q;

  // control state
  state_e          state_q, state_d;
  logic [KeyW-1:0] clr_cnt_q, clr_cnt_d;
  logic [VW-1:0]   rr_q, rr_d;
  logic [CntW-1:0] scan_cnt_q, scan_cnt_d;
  logic            ev_vld_q, ev_vld_d;
  logic            pass_q, pass_d;
  act_e            act_q, act_d;
  logic            out_valid_q, out_valid_d;
  logic [TuneW-1:0] octave_q, fifth_q;

  // item payload
  logic             cmd_q, cmd_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [VelW-1:0]  vel_q, vel_d;
  logic [KeyW-1:0]  old_note_q, old_note_d;
  logic [VW-1:0]    ev_idx_q, ev_idx_d;
  logic [VoiceOutW-1:0] voice_q, voice_d;
  logic [MaskW-1:0] mask_q, mask_d;
  logic signed [PitchW-1:0] acc_q, acc_d;

  // output register
  logic             out_load;
  act_e             out_act_q;
  logic [VoiceOutW-1:0] out_voice_q;
  logic [MaskW-1:0] out_mask_q;
  logic signed [PitchW-1:0] out_pitch_q;
  logic [VelW-1:0]  out_level_q;

  // pitch pipeline
  logic [KeyW-1:0]    pkey;
  logic [12:0]        div_prod;
  logic [3:0]         quot;
  logic [KeyW-1:0]    quot12;
  logic [3:0]         note_n;
  logic signed [4:0]  oct_s;
  logic signed [4:0]  m1_d, m1_q;
  logic signed [4:0]  m2_d, m2_q;
  logic signed [4:0]  oct_q;
  logic [17:0]        ji_q;
  logic signed [14:0] oct_size, fifth_size;
  logic signed [19:0] prod1_d, prod1_q, prod2_d, prod2_q;
  logic signed [21:0] jsum_d, jsum_q;
  logic signed [PitchW-1:0] tsum, temp_p, key_p;
  logic               ji_mode;

  // scan helpers
  logic [CntW-1:0] rr_sum;
  logic [VW-1:0]   scan_addr;
  logic            scan_last;
  logic            adj_hit;
  logic [VW-1:0]   idx_next;
  logic            note_on;

  assign ji_mode = (octave_q == '0) && (fifth_q == '0);

  // key / 12 by reciprocal, exact for seven-bit keys
  assign pkey     = pass_q ? old_note_q : key_q;
  assign div_prod = 13'(pkey) * 13'd43;
  assign quot     = div_prod[12:9];
  assign quot12   = KeyW'({3'b000, quot} * 7'd12);
  assign note_n   = 4'(pkey - quot12);
  assign oct_s    = $signed({1'b0, quot}) - 5'sd5;
  assign m1_d     = oct_s + 5'(oct_step(note_n)) + 5'sd1;
  assign m2_d     = fifth_step(note_n) - 5'sd3;

  assign oct_size   = OctaveBase + $signed({8'b0, octave_q});
  assign fifth_size = FifthBase + $signed({8'b0, fifth_q});
  assign prod1_d    = 20'(oct_size) * 20'(m1_q);
  assign prod2_d    = 20'(fifth_size) * 20'(m2_q);
  assign jsum_d     = 22'(oct_q) * JiOctave + $signed({4'b0000, ji_q});

  assign tsum   = PitchW'(prod1_q) + PitchW'(prod2_q);
  assign temp_p = (tsum <<< 4) + (tsum <<< 2);
  assign key_p  = ji_mode ? PitchW'(jsum_q) : temp_p;

  // round-robin address wraps once at most
  always_comb begin
    rr_sum = {1'b0, rr_q} + scan_cnt_q;
    if (rr_sum >= CntW'(VOICES)) begin
      rr_sum = rr_sum - CntW'(VOICES);
    end
  end

  assign scan_addr = (state_q == ST_RR) ? rr_sum[VW-1:0] : scan_cnt_q[VW-1:0];
  assign scan_last = (scan_cnt_q == CntW'(VOICES));
  assign adj_hit   = (vm_rdata_q.level != '0) &&
                     (({1'b0, vm_rdata_q.note} + 8'd1 == {1'b0, key_q}) ||
                      ({1'b0, vm_rdata_q.note} == {1'b0, key_q} + 8'd1));
  assign idx_next  = (ev_idx_q == VW'(VOICES - 1)) ? '0 : ev_idx_q + 1'b1;
  assign note_on   = cmd_q && (vel_q != '0);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    rr_d        = rr_q;
    scan_cnt_d  = scan_cnt_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = ev_idx_q;
    pass_d      = pass_q;
    act_d       = act_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    vel_d       = vel_q;
    old_note_d  = old_note_q;
    voice_d     = voice_q;
    mask_d      = mask_q;
    acc_d       = acc_q;
    out_load    = 1'b0;
    pk_we       = 1'b0;
    pk_waddr    = key_q;
    pk_wdata    = 1'b0;
    vm_we       = 1'b0;
    vm_waddr    = ev_idx_q;
    vm_wdata    = vm_rdata_q;
    vm_raddr    = scan_addr;

    unique case (state_q)
      ST_CLEAR: begin
        pk_we     = 1'b1;
        pk_waddr  = clr_cnt_q;
        if (clr_cnt_q < KeyW'(VOICES)) begin
          vm_we    = 1'b1;
          vm_waddr = clr_cnt_q[VW-1:0];
          vm_wdata = '0;
        end
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == KeyW'(NumKeys - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          key_d   = key_i;
          vel_d   = velocity_i;
          act_d   = ACT_NONE;
          voice_d = '0;
          mask_d  = '0;
          acc_d   = '0;
          pass_d  = 1'b0;
          state_d = ST_KEY;
        end
      end
      ST_KEY: begin
        scan_cnt_d = '0;
        if (note_on) begin
          if (!pk_rdata_q) begin
            pk_we    = 1'b1;
            pk_wdata = 1'b1;
            state_d  = ST_GLIDE;
          end else begin
            state_d = ST_DONE;
          end
        end else if (pk_rdata_q) begin
          pk_we    = 1'b1;
          pk_wdata = 1'b0;
          act_d    = ACT_RELEASE;
          state_d  = ST_REL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_GLIDE, ST_RR, ST_REL: begin
        // issue the next voice read while the previous one is evaluated
        if (!scan_last) begin
          ev_vld_d   = 1'b1;
          ev_idx_d   = scan_addr;
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
        if (ev_vld_q) begin
          if (state_q == ST_GLIDE) begin
            if (adj_hit) begin
              vm_we         = 1'b1;
              vm_wdata.note = key_q;
              old_note_d    = vm_rdata_q.note;
              voice_d       = VoiceOutW'(ev_idx_q);
              act_d         = ACT_GLIDE;
              ev_vld_d      = 1'b0;
              state_d       = ST_P1;
            end else if (scan_last) begin
              scan_cnt_d = '0;
              state_d    = ST_RR;
            end
          end else if (state_q == ST_RR) begin
            if (vm_rdata_q.level == '0) begin
              vm_we          = 1'b1;
              vm_wdata.note  = key_q;
              vm_wdata.level = vel_q;
              rr_d           = idx_next;
              voice_d        = VoiceOutW'(ev_idx_q);
              act_d          = ACT_START;
              ev_vld_d       = 1'b0;
              state_d        = ST_P1;
            end else if (scan_last) begin
              state_d = ST_DONE;
            end
          end else begin
            if (vm_rdata_q.note == key_q) begin
              vm_we          = 1'b1;
              vm_wdata.level = '0;
              if (vm_rdata_q.level != '0) begin
                mask_d = mask_q | MaskW'(1 << ev_idx_q);
              end
            end
            if (scan_last) begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_P1: begin
        state_d = ST_P2;
      end
      ST_P2: begin
        state_d = ST_P3;
      end
      ST_P3: begin
        if (!pass_q) begin
          acc_d = (act_q == ACT_START) ? (key_p <<< 1) : key_p;
        end else begin
          acc_d = acc_q + key_p;
        end
        if ((act_q == ACT_GLIDE) && !pass_q) begin
          pass_d  = 1'b1;
          state_d = ST_P1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      rr_q        <= '0;
      scan_cnt_q  <= '0;
      ev_vld_q    <= 1'b0;
      pass_q      <= 1'b0;
      act_q       <= ACT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      rr_q        <= rr_d;
      scan_cnt_q  <= scan_cnt_d;
      ev_vld_q    <= ev_vld_d;
      pass_q      <= pass_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_q <= TuneReset;
      fifth_q  <= TuneReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOctave: octave_q <= cfg_data_i;
        CfgFifth:  fifth_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    vel_q      <= vel_d;
    old_note_q <= old_note_d;
    ev_idx_q   <= ev_idx_d;
    voice_q    <= voice_d;
    mask_q     <= mask_d;
    acc_q      <= acc_d;
    // pitch pipeline runs freely, the sequencer picks the valid stage
    m1_q       <= m1_d;
    m2_q       <= m2_d;
    oct_q      <= oct_s;
    ji_q       <= ji_cents(note_n);
    prod1_q    <= prod1_d;
    prod2_q    <= prod2_d;
    jsum_q     <= jsum_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_act_q   <= act_q;
      out_voice_q <= voice_q;
      out_mask_q  <= mask_q;
      out_pitch_q <= acc_q;
      out_level_q <= (act_q == ACT_START) ? vel_q : '0;
    end
  end

  // key map memory, read at the transfer edge
  always_ff @(posedge clk_i) begin
    if (pk_we) begin
      pk_mem[pk_waddr] <= pk_wdata;
    end
    pk_rdata_q <= pk_mem[key_i];
  end

  // voice table memory
  always_ff @(posedge clk_i) begin
    if (vm_we) begin
      vm_mem[vm_waddr] <= vm_wdata;
    end
    vm_rdata_q <= vm_mem[vm_raddr];
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign action_o       = out_act_q;
  assign voice_o        = out_voice_q;
  assign release_mask_o = out_mask_q;
  assign pitch_o        = out_pitch_q;
  assign level_o        = out_level_q;

endmodule

[test/tb.sv]
// self-checking testbench of the polyphonic voice allocator with its own allocation model
module tb;
  import pva_pkg::*;

  localparam int NumVoices  = VoicesDef;
  localparam int CycleLimit = 1000000;
  localparam int SettleWait = 40;
  localparam int LongHold   = 300;
  localparam int PhaseItems = 300;

  // pitch tables in 1/200 cent (just) and octave/fifth steps from c
  localparam int JustSteps[12]  = '{0, 20991, 40782, 59503, 77263, 94156,
                                    110264, 140391, 168106, 181173, 193765, 217654};
  localparam int OctSteps[12]   = '{0, -4, -1, 2, -2, 1, -3, 0, -4, -1, 2, -2};
  localparam int FifthSteps[12] = '{0, 7, 2, -3, 4, -1, 6, 1, 8, 3, -2, 5};

  typedef struct packed {
    logic [1:0]               action;
    logic [VoiceOutW-1:0]     voice;
    logic [MaskW-1:0]         mask;
    logic signed [PitchW-1:0] pitch;
    logic [VelW-1:0]          level;
  } alloc_result_t;

  class allocator_scoreboard;
    bit [TuneW-1:0] oct_tune;
    bit [TuneW-1:0] fifth_tune;
    bit             pressed[NumKeys];
    bit [KeyW-1:0]  note_of[NumVoices];
    bit [VelW-1:0]  level_of[NumVoices];
    int unsigned    rr_next;
    alloc_result_t  pending_results[$];
    int             errors;
    int             act_count[4];
    int             events_seen;

    function new();
      oct_tune   = TuneReset;
      fifth_tune = TuneReset;
      rr_next    = 0;
      errors     = 0;
      events_seen = 0;
      foreach (pressed[k]) pressed[k] = 1'b0;
      foreach (note_of[v]) begin
        note_of[v]  = '0;
        level_of[v] = '0;
      end
      foreach (act_count[a]) act_count[a] = 0;
    endfunction

    function void set_tuning(bit [CfgIdxW-1:0] idx, bit [TuneW-1:0] value);
      if (idx == CfgOctave) oct_tune = value;
      else if (idx == CfgFifth) fifth_tune = value;
    endfunction

    // key pitch in 1/200 cent
    function int pitch_of_key(int k);
      int n;
      int oc;
      n  = k % 12;
      oc = k / 12 - 5;
      if (oct_tune == 0 && fifth_tune == 0) return 240000 * oc + JustSteps[n];
      return 20 * ((11936 + int'(oct_tune)) * (oc + OctSteps[n] + 1)
                 + (6936 + int'(fifth_tune)) * (FifthSteps[n] - 3));
    endfunction

    // accepted event: update allocation state and queue the expected result
    function void note_event(bit cmd, bit [KeyW-1:0] key, bit [VelW-1:0] vel);
      alloc_result_t r;
      bit            done;
      int            k;
      int            nk;
      int unsigned   c;
      r = '0;
      r.action = ACT_NONE;
      k = key;
      events_seen++;
      if (cmd && vel != 0) begin
        if (!pressed[k]) begin
          pressed[k] = 1'b1;
          done = 1'b0;
          for (int v = 0; v < NumVoices && !done; v++) begin
            nk = note_of[v];
            if (level_of[v] != 0 && (nk + 1 == k || nk == k + 1)) begin
              r.pitch  = PitchW'(pitch_of_key(k) + pitch_of_key(nk));
              note_of[v] = key;
              r.action = ACT_GLIDE;
              r.voice  = VoiceOutW'(v);
              done = 1'b1;
            end
          end
          for (int n = 0; n < NumVoices && !done; n++) begin
            c = rr_next;
            rr_next = (rr_next + 1 >= NumVoices) ? 0 : rr_next + 1;
            if (level_of[c] == 0) begin
              note_of[c]  = key;
              level_of[c] = vel;
              r.pitch  = PitchW'(2 * pitch_of_key(k));
              r.action = ACT_START;
              r.voice  = VoiceOutW'(c);
              r.level  = vel;
              done = 1'b1;
            end
          end
        end
      end else if (pressed[k]) begin
        pressed[k] = 1'b0;
        r.action = ACT_RELEASE;
        for (int v = 0; v < NumVoices; v++) begin
          if (note_of[v] == key) begin
            if (level_of[v] != 0 && v < MaskW) r.mask[v] = 1'b1;
            level_of[v] = '0;
          end
        end
      end
      act_count[r.action]++;
      pending_results.push_back(r);
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got action %0d", $time, got.action);
        return;
      end
      want = pending_results.pop_front();
      if (got.action !== want.action) report("action", want.action, got.action);
      if (got.voice !== want.voice) report("voice", want.voice, got.voice);
      if (got.mask !== want.mask) report("release_mask", want.mask, got.mask);
      if (got.pitch !== want.pitch) report("pitch", want.pitch, got.pitch);
      if (got.level !== want.level) report("level", want.level, got.level);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   cmd_i;
  logic [KeyW-1:0]        key_i;
  logic [VelW-1:0]        velocity_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [1:0]             action_o;
  logic [VoiceOutW-1:0]   voice_o;
  logic [MaskW-1:0]       release_mask_o;
  logic signed [PitchW-1:0] pitch_o;
  logic [VelW-1:0]        level_o;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [TuneW-1:0]       cfg_data_i;

  allocator_scoreboard sb = new();
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  long_hold = 1'b0;
  bit  reset_done = 1'b0;
  bit  stim_held[NumKeys];
  int  key_base = 48;

  poly_voice_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .velocity_i    (velocity_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .voice_o       (voice_o),
    .release_mask_o(release_mask_o),
    .pitch_o       (pitch_o),
    .level_o       (level_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = 1'b0;
    key_i       = '0;
    velocity_i  = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgOctave;
    cfg_data_i  = '0;
    foreach (stim_held[k]) stim_held[k] = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // input transfers feed the model, output transfers are checked
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_event(cmd_i, key_i, velocity_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{action_o, voice_o, release_mask_o, pitch_o, level_o});
  end

  // receiver: random stall bursts, always ready in the calm phase, one long hold-off on request
  initial begin
    int n;
    wait (reset_done);
    @(posedge clk_i);
    forever begin
      if (calm) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        n = $urandom_range(1, 16);
        out_ready_i <= ($urandom_range(0, 99) < 60);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_event(bit cmd, int key, int vel);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    key_i      <= KeyW'(key);
    velocity_i <= VelW'(vel);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic play(bit cmd, int key, int vel);
    stim_held[key] = cmd && vel != 0;
    send_event(cmd, key, vel);
  endtask

  task automatic wait_results();
    // let the monitor queue the last input transfer before the pending results are checked
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait_results();
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_tuning(int oct, int fifth);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgOctave;
    cfg_data_i <= TuneW'(oct);
    sb.set_tuning(CfgOctave, TuneW'(oct));
    @(posedge clk_i);
    cfg_idx_i  <= CfgFifth;
    cfg_data_i <= TuneW'(fifth);
    sb.set_tuning(CfgFifth, TuneW'(fifth));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly note on/off pairs in a narrow window so glides, repeats and full voice tables occur
  task automatic random_event();
    int pick;
    int held_n;
    int nth;
    int k;
    held_n = 0;
    foreach (stim_held[i]) if (stim_held[i]) held_n++;
    if ($urandom_range(0, 49) == 0) key_base = $urandom_range(0, 116);
    pick = $urandom_range(0, 99);
    if (held_n > 10 && pick < 45) pick = 50;
    if (pick >= 45 && pick < 75 && held_n == 0) pick = 0;
    if (pick < 45) begin
      play(1'b1, key_base + $urandom_range(0, 11), $urandom_range(1, 127));
    end else if (pick < 75) begin
      nth = $urandom_range(0, held_n - 1);
      k = 0;
      foreach (stim_held[i]) begin
        if (stim_held[i]) begin
          if (nth == 0) k = i;
          nth--;
        end
      end
      // velocity zero note on acts as note off
      if ($urandom_range(0, 3) == 0) play(1'b1, k, 0);
      else play(1'b0, k, $urandom_range(0, 127));
    end else if (pick < 85) begin
      play(1'b1, $urandom_range(0, 127), $urandom_range(0, 127));
    end else if (pick < 95) begin
      play(1'b0, key_base + $urandom_range(0, 11), $urandom_range(0, 127));
    end else begin
      play(1'b0, $urandom_range(0, 127), $urandom_range(0, 127));
    end
  endtask

  initial begin
    int oct_set[6];
    int fifth_set[6];
    oct_set   = '{0, 127, 0, 127, 0, 0};
    fifth_set = '{0, 127, 127, 0, 0, 0};
    oct_set[4]   = $urandom_range(1, 126);
    fifth_set[4] = $urandom_range(1, 126);
    oct_set[5]   = $urandom_range(0, 127);
    fifth_set[5] = $urandom_range(1, 127);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    reset_done = 1'b1;
    @(posedge clk_i);
    write_tuning(TuneReset, TuneReset);

    // directed: edge keys, glides both ways, repeats, stray note offs, full voice table
    play(1'b1, 0, 127);
    play(1'b1, 1, 1);
    play(1'b1, 127, 64);
    play(1'b1, 126, 5);
    play(1'b1, 1, 10);
    play(1'b1, 60, 0);
    play(1'b0, 0, 0);
    play(1'b0, 1, 127);
    play(1'b0, 50, 85);
    for (int i = 0; i < 9; i++) play(1'b1, 20 + 3 * i, (i == 0) ? 42 : 85 + 4 * i);
    play(1'b1, 20, 0);
    play(1'b0, 126, 0);
    play(1'b0, 23, 127);
    play(1'b1, 90, 127);
    play(1'b1, 91, 127);

    for (int p = 0; p < 6; p++) begin
      drain();
      write_tuning(oct_set[p], fifth_set[p]);
      calm = (p == 5);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 1 && i == PhaseItems / 2) long_hold = 1'b1;
        if (p == 2 && i == PhaseItems / 2) begin
          in_valid_i <= 1'b0;
          wait_results();
        end
        random_event();
      end
    end

    drain();
    $display("covered %0d events under 7 tuning settings incl. just intonation and extremes",
             sb.events_seen);
    $display("results: %0d none, %0d starts, %0d glides, %0d releases",
             sb.act_count[ACT_NONE], sb.act_count[ACT_START],
             sb.act_count[ACT_GLIDE], sb.act_count[ACT_RELEASE]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
